// File: rtl/sjsr_pkg.sv
// Package: types, codes and constants of the servo joint slew ramp.
package sjsr_pkg;

  localparam logic [1:0] OP_SET_TARGET = 2'd0;
  localparam logic [1:0] OP_SET_ANGLE  = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [1:0] CFG_PULSE_MAX = 2'd1;
  localparam logic [1:0] CFG_LEG_MASK  = 2'd2;

  localparam logic [11:0] PULSE_MIN_RST = 12'd150;
  localparam logic [11:0] PULSE_MAX_RST = 12'd600;
  localparam logic [5:0]  LEG_MASK_RST  = 6'd63;
  localparam logic [7:0]  ANGLE_MAX     = 8'd180;

  // floor(2^32 / 180); quotient estimate is exact or one low
  localparam logic [24:0] RECIP_180 = 25'd23860929;
  localparam int          RECIP_SHIFT = 32;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] leg;
    logic [1:0] joint;
    logic [7:0] angle;
  } sjsr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        board;
    logic [3:0]  channel;
    logic [11:0] pulse;
    logic [2:0]  out_leg;
    logic [1:0]  out_joint;
    logic [7:0]  out_angle;
    logic        last;
  } sjsr_out_t;

  typedef struct packed {
    logic       board;
    logic [3:0] channel;
  } sjsr_chan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_PULSE,
    ST_LAST,
    ST_SCAN,
    ST_TPUSH,
    ST_FLUSH
  } sjsr_state_e;

  typedef enum logic [1:0] {
    PU_IDLE,
    PU_MUL,
    PU_RECIP,
    PU_FIX
  } sjsr_pu_state_e;

  function automatic logic [7:0] home_angle(input logic [1:0] j0);
    logic [7:0] a;
    case (j0)
      2'd1:    a = 8'd153;
      2'd2:    a = 8'd160;
      default: a = 8'd90;
    endcase
    return a;
  endfunction

  // board = (leg-1)/3 mod 2, channel = ((leg-1) mod 3)*4 + joint-1
  function automatic sjsr_chan_t chan_of(input logic [2:0] leg0, input logic [1:0] j0);
    sjsr_chan_t c;
    logic [3:0] base;
    case (leg0)
      3'd0:    begin c.board = 1'b0; base = 4'd0; end
      3'd1:    begin c.board = 1'b0; base = 4'd4; end
      3'd2:    begin c.board = 1'b0; base = 4'd8; end
      3'd3:    begin c.board = 1'b1; base = 4'd0; end
      3'd4:    begin c.board = 1'b1; base = 4'd4; end
      3'd5:    begin c.board = 1'b1; base = 4'd8; end
      3'd6:    begin c.board = 1'b0; base = 4'd0; end
      default: begin c.board = 1'b0; base = 4'd4; end
    endcase
    c.channel = base + 4'(j0);
    return c;
  endfunction

endpackage

// File: rtl/sjsr_pulse.sv
// Pulse unit: min + angle*(max-min)/180 on one shared multiplier, in steps MUL, RECIP and FIX.
module sjsr_pulse import sjsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  angle_i,
  input  logic [11:0] pulse_min_i,
  input  logic [11:0] pulse_max_i,
  output logic        done_o,
  output logic [11:0] pulse_o
);

  sjsr_pu_state_e st_q, st_d;
  logic [7:0]  ang_q, ang_d;
  logic [19:0] prod_q, prod_d;
  logic [11:0] quo_q, quo_d;

  logic [12:0] diff;
  logic        neg;
  logic [11:0] mag;
  logic [19:0] mul_a;
  logic [24:0] mul_b;
  logic [44:0] mul_p;
  logic [19:0] rem;
  logic [11:0] quo_fix;

  assign diff = {1'b0, pulse_max_i} - {1'b0, pulse_min_i};
  assign neg  = diff[12];
  assign mag  = neg ? 12'(-diff) : diff[11:0];

  assign mul_a = (st_q == PU_RECIP) ? prod_q : 20'(ang_q);
  assign mul_b = (st_q == PU_RECIP) ? RECIP_180 : 25'(mag);
  assign mul_p = {25'd0, mul_a} * {20'd0, mul_b};

  assign rem     = prod_q - 20'(quo_q) * 20'd180;
  assign quo_fix = (rem >= 20'(ANGLE_MAX)) ? quo_q + 12'd1 : quo_q;

  assign done_o  = (st_q == PU_FIX);
  assign pulse_o = neg ? pulse_min_i - quo_fix : pulse_min_i + quo_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PU_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q  <= ang_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    st_d   = st_q;
    ang_d  = ang_q;
    prod_d = prod_q;
    quo_d  = quo_q;
    case (st_q)
      PU_IDLE: begin
        if (start_i) begin
          ang_d = angle_i;
          st_d  = PU_MUL;
        end
      end
      PU_MUL: begin
        prod_d = mul_p[19:0];
        st_d   = PU_RECIP;
      end
      PU_RECIP: begin
        quo_d = mul_p[RECIP_SHIFT +: 12];
        st_d  = PU_FIX;
      end
      PU_FIX: begin
        st_d = PU_IDLE;
      end
      default: st_d = PU_IDLE;
    endcase
  end

endmodule

// File: rtl/servo_joint_slew_ramp.sv
// Top level: per-joint angle/target tracker with one-degree slew per tick.
//
//  channel   dir  handshake          payload
//  in        in   in_valid_i/stall   sjsr_in_t  (op, leg, joint, angle)
//  out       out  out_valid_o/stall  sjsr_out_t (kind .. last)
//  cfg       in   cfg_valid_i/ready  cfg_index_i, cfg_data_i
//
// Set target or reject: states SET, LAST; direct set: SET, PULSE (waits for the pulse unit), LAST.
// Tick: SCAN visits each joint in turn; each joint that moves passes through PULSE and TPUSH;
// FLUSH then sends the final transfer, or a DONE item when no joint moved.
// Reset restores home angles and config defaults at once; no clearing pass.
// in_stall_o is high while an item is in work; a result waiting in the output
// register does not stall input. cfg_ready_o is always high.
module servo_joint_slew_ramp import sjsr_pkg::*; #(
  parameter int NUM_LEGS       = 6,
  parameter int JOINTS_PER_LEG = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sjsr_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sjsr_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int NJ    = NUM_LEGS * JOINTS_PER_LEG;
  localparam int LEG_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
  localparam int JNT_W = (JOINTS_PER_LEG > 1) ? $clog2(JOINTS_PER_LEG) : 1;
  localparam int IDX_W = (NJ > 1) ? $clog2(NJ) : 1;

  sjsr_state_e       state_q, state_d;
  sjsr_in_t          item_q, item_d;
  logic [LEG_W-1:0]  leg_cnt_q, leg_cnt_d;
  logic [JNT_W-1:0]  jnt_cnt_q, jnt_cnt_d;
  sjsr_out_t         res_q, res_d;
  sjsr_out_t         pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  sjsr_out_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;
  logic [11:0]       pmin_q, pmax_q;
  logic [5:0]        mask_q;

  logic [7:0]        ja_q [NJ];
  logic [7:0]        ta_q [NJ];

  logic              is_tick;
  logic [2:0]        set_leg0, leg0;
  logic [1:0]        set_j0, j0;
  logic              set_leg_ok, set_jnt_ok;
  logic [IDX_W-1:0]  acc_idx;
  logic [7:0]        mask8;
  logic              present;
  logic [7:0]        cur, tgt, step_ang;
  sjsr_chan_t        chan;
  logic              last_pos, adv, out_free;
  logic              ja_we, ta_we;
  logic [7:0]        ja_wd;
  logic              pu_start, pu_done;
  logic [7:0]        pu_angle;
  logic [11:0]       pu_pulse;

  sjsr_pulse u_pulse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pu_start),
    .angle_i    (pu_angle),
    .pulse_min_i(pmin_q),
    .pulse_max_i(pmax_q),
    .done_o     (pu_done),
    .pulse_o    (pu_pulse)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || !out_stall_i;

  assign is_tick    = (item_q.op == OP_TICK);
  assign set_leg0   = item_q.leg - 3'd1;
  assign set_j0     = item_q.joint - 2'd1;
  assign set_leg_ok = (item_q.leg != 3'd0) && (4'(item_q.leg) <= 4'(NUM_LEGS));
  assign set_jnt_ok = (item_q.joint != 2'd0) && (3'(item_q.joint) <= 3'(JOINTS_PER_LEG));
  assign leg0       = is_tick ? 3'(leg_cnt_q) : set_leg0;
  assign j0         = is_tick ? 2'(jnt_cnt_q) : set_j0;
  assign acc_idx    = IDX_W'(int'(leg0) * JOINTS_PER_LEG + int'(j0));
  assign mask8      = {2'b00, mask_q};
  assign present    = mask8[leg0];
  assign cur        = ja_q[acc_idx];
  assign tgt        = ta_q[acc_idx];
  assign step_ang   = (cur < tgt) ? cur + 8'd1 : cur - 8'd1;
  assign chan       = chan_of(leg0, j0);
  assign last_pos   = (leg_cnt_q == LEG_W'(NUM_LEGS - 1)) &&
                      (jnt_cnt_q == JNT_W'(JOINTS_PER_LEG - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= PULSE_MIN_RST;
      pmax_q <= PULSE_MAX_RST;
      mask_q <= LEG_MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PULSE_MIN: pmin_q <= cfg_data_i;
        CFG_PULSE_MAX: pmax_q <= cfg_data_i;
        CFG_LEG_MASK:  mask_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NJ; g++) begin : g_ent
    localparam logic [7:0] HOME_ANG = home_angle(2'(g % JOINTS_PER_LEG));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ja_q[g] <= HOME_ANG;
        ta_q[g] <= HOME_ANG;
      end else begin
        if (ja_we && acc_idx == IDX_W'(g)) begin
          ja_q[g] <= ja_wd;
        end
        if (ta_we && acc_idx == IDX_W'(g)) begin
          ta_q[g] <= item_q.angle;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      leg_cnt_q  <= '0;
      jnt_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      leg_cnt_q  <= leg_cnt_d;
      jnt_cnt_q  <= jnt_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    leg_cnt_d  = leg_cnt_q;
    jnt_cnt_d  = jnt_cnt_q;
    res_d      = res_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    ja_we      = 1'b0;
    ta_we      = 1'b0;
    ja_wd      = item_q.angle;
    pu_start   = 1'b0;
    pu_angle   = item_q.angle;
    adv        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          leg_cnt_d = '0;
          jnt_cnt_d = '0;
          if (in_data_i.angle > ANGLE_MAX) begin
            item_d.angle = ANGLE_MAX;
          end
          case (in_data_i.op)
            OP_SET_TARGET, OP_SET_ANGLE: state_d = ST_SET;
            OP_TICK:                     state_d = ST_SCAN;
            default:                     state_d = ST_IDLE;
          endcase
        end
      end
      ST_SET: begin
        res_d = '0;
        if (!(set_leg_ok && set_jnt_ok && (present || item_q.op == OP_SET_ANGLE))) begin
          res_d.kind = KIND_REJECT;
          state_d    = ST_LAST;
        end else begin
          ta_we           = 1'b1;
          res_d.out_leg   = item_q.leg;
          res_d.out_joint = item_q.joint;
          res_d.out_angle = item_q.angle;
          if (item_q.op == OP_SET_TARGET) begin
            res_d.kind = KIND_ACCEPT;
            state_d    = ST_LAST;
          end else begin
            ja_we         = 1'b1;
            pu_start      = 1'b1;
            res_d.kind    = KIND_WRITE;
            res_d.board   = chan.board;
            res_d.channel = chan.channel;
            state_d       = ST_PULSE;
          end
        end
      end
      ST_PULSE: begin
        if (pu_done) begin
          res_d.pulse = pu_pulse;
          state_d     = is_tick ? ST_TPUSH : ST_LAST;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_d      = res_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (present && cur != tgt) begin
          ja_we           = 1'b1;
          ja_wd           = step_ang;
          pu_angle        = step_ang;
          pu_start        = 1'b1;
          res_d           = '0;
          res_d.kind      = KIND_WRITE;
          res_d.board     = chan.board;
          res_d.channel   = chan.channel;
          res_d.out_leg   = leg0 + 3'd1;
          res_d.out_joint = j0 + 2'd1;
          res_d.out_angle = step_ang;
          state_d         = ST_PULSE;
        end else begin
          adv     = 1'b1;
          state_d = last_pos ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_TPUSH: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_d     = pend_q;
            out_vld_d = 1'b1;
          end
          pend_d     = res_q;
          pend_vld_d = 1'b1;
          adv        = 1'b1;
          state_d    = last_pos ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_vld_q) begin
            out_d = pend_q;
          end else begin
            out_d      = '0;
            out_d.kind = KIND_DONE;
          end
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (adv) begin
      if (jnt_cnt_q == JNT_W'(JOINTS_PER_LEG - 1)) begin
        jnt_cnt_d = '0;
        leg_cnt_d = leg_cnt_q + LEG_W'(1);
      end else begin
        jnt_cnt_d = jnt_cnt_q + JNT_W'(1);
      end
    end
  end

  a_pend_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> item_q.op == OP_TICK)
    else $error("pending write outside a tick");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_vld_q)
    else $error("pending write left behind at idle");

  a_pu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pu_done |-> state_q == ST_PULSE)
    else $error("pulse result with no one waiting");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (cur <= ANGLE_MAX) && (tgt <= ANGLE_MAX))
    else $error("tracked angle out of range");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) && out_free |=> out_vld_q && out_q.last)
    else $error("tick ended without a final transfer");

endmodule
